[src/cbs_pkg.sv]
// ----------------------------------------------------------------------------
// Cell balance selector package
// Shared widths, reset values, register codes, state and control types.
// ----------------------------------------------------------------------------
package cbs_pkg;

	// Default depth of the per-chip voltage store.
	localparam int unsigned MAX_CELLS_DEF = 12;

	// Fixed field widths.
	localparam int unsigned VOLT_W     = 16;
	localparam int unsigned LIMIT_W    = VOLT_W + 1;
	localparam int unsigned MASK_OUT_W = 12;
	localparam int unsigned CNT_OUT_W  = 4;
	localparam int unsigned MAXB_W     = 4;
	localparam int unsigned CFG_DATA_W = 16;

	// Register reset values.
	localparam logic [VOLT_W-1:0] THRESHOLD_RST = 16'd100;
	localparam logic [MAXB_W-1:0] MAX_BAL_RST   = 4'd8;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_BALANCE_THRESHOLD = 1'b0,
		REG_MAX_BALANCED      = 1'b1
	} cfg_reg_t;

	// Selection sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_RANK,
		S_DONE
	} sel_state_t;

	// Control from the frame logic to the selection sequencer.
	typedef struct packed {
		logic               start;
		logic               ack;
		logic [LIMIT_W-1:0] limit;
		logic [MAXB_W-1:0]  max_balanced;
	} sel_ctrl_t;

	// Status from the selection sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} sel_stat_t;

	// Index width for a store of the given depth.
	function automatic int unsigned idx_width(input int unsigned depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

	// Counter width that holds the depth itself and at least a 4-bit limit.
	function automatic int unsigned cnt_width(input int unsigned depth);
		return ($clog2(depth + 1) > 4) ? $clog2(depth + 1) : 4;
	endfunction

	// Internal mask width: the store depth, at least the output mask width.
	function automatic int unsigned mask_width(input int unsigned depth);
		return (depth > MASK_OUT_W) ? depth : MASK_OUT_W;
	endfunction

endpackage

[src/cbs_cell_if.sv]
// ----------------------------------------------------------------------------
// Cell voltage channel
// Valid/ready channel carrying one cell voltage request per transfer.
// ----------------------------------------------------------------------------
interface cbs_cell_if;
	import cbs_pkg::*;

	logic              valid;
	logic              ready;
	logic [VOLT_W-1:0] cell_voltage;
	logic [VOLT_W-1:0] pack_min_voltage;
	logic              last_cell;

	modport source (
		output valid, cell_voltage, pack_min_voltage, last_cell,
		input  ready
	);

	modport sink (
		input  valid, cell_voltage, pack_min_voltage, last_cell,
		output ready
	);

endinterface

[src/cbs_result_if.sv]
// ----------------------------------------------------------------------------
// Balance result channel
// Valid/ready channel carrying one discharge mask request per chip frame.
// ----------------------------------------------------------------------------
interface cbs_result_if;
	import cbs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [MASK_OUT_W-1:0] discharge_mask;
	logic [CNT_OUT_W-1:0]  balanced_count;
	logic                  overflow;

	modport source (
		output valid, discharge_mask, balanced_count, overflow,
		input  ready
	);

	modport sink (
		input  valid, discharge_mask, balanced_count, overflow,
		output ready
	);

endinterface

[src/cbs_store.sv]
// ----------------------------------------------------------------------------
// Cell voltage store
// Register file holding the voltages of the current frame, one write port
// and one read port whose address the selection sequencer drives.
// ----------------------------------------------------------------------------
module cbs_store #(
	parameter int unsigned DEPTH = cbs_pkg::MAX_CELLS_DEF,
	parameter int unsigned IDX_W = cbs_pkg::idx_width(DEPTH)
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [IDX_W-1:0]          wr_idx,
	input  logic [cbs_pkg::VOLT_W-1:0] wr_data,
	input  logic [IDX_W-1:0]          rd_idx,
	output logic [cbs_pkg::VOLT_W-1:0] rd_data
);
	import cbs_pkg::*;

	logic [VOLT_W-1:0] mem_q [DEPTH];

	// Entries are written as cells arrive; no reset, each is written before use.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
	end

	assign rd_data = mem_q[rd_idx];

endmodule

[src/cbs_select.sv]
// ----------------------------------------------------------------------------
// Selection sequencer
// Walks the stored cells, ranks each qualifying cell against all others with
// one shared compare and counter, and builds the discharge mask.
// ----------------------------------------------------------------------------
module cbs_select #(
	parameter int unsigned DEPTH = cbs_pkg::MAX_CELLS_DEF,
	parameter int unsigned IDX_W = cbs_pkg::idx_width(DEPTH),
	parameter int unsigned CNT_W = cbs_pkg::cnt_width(DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cbs_pkg::sel_ctrl_t            ctrl,
	input  logic [CNT_W-1:0]              cell_count,
	output logic [IDX_W-1:0]              rd_idx,
	input  logic [cbs_pkg::VOLT_W-1:0]    rd_data,
	output cbs_pkg::sel_stat_t            stat,
	output logic [cbs_pkg::MASK_OUT_W-1:0] mask,
	output logic [cbs_pkg::CNT_OUT_W-1:0]  count
);
	import cbs_pkg::*;

	localparam int unsigned MASK_W = mask_width(DEPTH);

	sel_state_t        state_q, state_d;
	logic [CNT_W-1:0]  n_q, m_q, rank_q, count_q;
	logic [CNT_W-1:0]  rank_nx;
	logic [MASK_W-1:0] mask_q;
	logic [VOLT_W-1:0] v_q;

	logic qualifies, beats, last_m;
	logic init, load_v, inc_n, step_m, rank_done;

	// Shared compare unit: threshold test and stable descending rank test.
	assign qualifies = {1'b0, rd_data} > ctrl.limit;
	assign beats     = (rd_data > v_q) || ((rd_data == v_q) && (m_q < n_q));
	assign rank_nx   = rank_q + CNT_W'(beats);
	assign last_m    = (m_q == (cell_count - CNT_W'(1)));
	assign rd_idx    = (state_q == S_RANK) ? m_q[IDX_W-1:0] : n_q[IDX_W-1:0];

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath strobes.
	always_comb begin
		state_d   = state_q;
		init      = 1'b0;
		load_v    = 1'b0;
		inc_n     = 1'b0;
		step_m    = 1'b0;
		rank_done = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (ctrl.start) begin
					init    = 1'b1;
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				if (n_q == cell_count) begin
					state_d = S_DONE;
				end else begin
					load_v = 1'b1;
					if (qualifies) begin
						state_d = S_RANK;
					end else begin
						inc_n = 1'b1;
					end
				end
			end
			S_RANK: begin
				if (last_m) begin
					rank_done = 1'b1;
					state_d   = S_LOAD;
				end else begin
					step_m = 1'b1;
				end
			end
			S_DONE: begin
				if (ctrl.ack) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Cell and rank counters, result accumulation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= '0;
			m_q     <= '0;
			rank_q  <= '0;
			count_q <= '0;
			mask_q  <= '0;
		end else begin
			if (init) begin
				n_q     <= '0;
				count_q <= '0;
				mask_q  <= '0;
			end
			if (load_v) begin
				m_q    <= '0;
				rank_q <= '0;
			end
			if (inc_n) begin
				n_q <= n_q + CNT_W'(1);
			end
			if (step_m) begin
				m_q    <= m_q + CNT_W'(1);
				rank_q <= rank_nx;
			end
			if (rank_done) begin
				if (rank_nx < CNT_W'(ctrl.max_balanced)) begin
					mask_q[n_q[IDX_W-1:0]] <= 1'b1;
					count_q                <= count_q + CNT_W'(1);
				end
				n_q <= n_q + CNT_W'(1);
			end
		end
	end

	// Voltage of the cell being ranked.
	always_ff @(posedge clk) begin
		if (load_v) begin
			v_q <= rd_data;
		end
	end

	assign stat.busy = (state_q != S_IDLE);
	assign stat.done = (state_q == S_DONE);
	assign mask      = mask_q[MASK_OUT_W-1:0];
	assign count     = count_q[CNT_OUT_W-1:0];

endmodule

[src/cell_balance_selector.sv]
// ----------------------------------------------------------------------------
// Cell balance selector
// Collects the cell voltages of one monitor chip and picks the cells that
// discharge: those above pack minimum plus a threshold, highest first,
// limited to a configured count, ties going to the lower cell index.
//
// Usage: cells arrive one request per cell on the cells channel, in cell
// order; last_cell marks the chip's final cell, whose pack_min_voltage sets
// the threshold. Cells that are not last are stored as they are taken. The
// last cell starts the selection: every stored cell is read once, and each
// qualifying cell is then compared against all N stored cells by one shared
// comparator, one cell per cycle. The cells channel is not ready during
// selection. Cells beyond the store depth are dropped and flagged. The
// result sits in an output register; the next frame's cells are taken while
// it waits, and a finished selection holds until the register frees. Reset
// clears the frame, the pending result, and restores the threshold to 10 mV
// and the limit to eight cells. Registers are written by cfg_we.
// ----------------------------------------------------------------------------
module cell_balance_selector #(
	parameter int unsigned MAX_CELLS = cbs_pkg::MAX_CELLS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  cbs_pkg::cfg_reg_t              cfg_index,
	input  logic [cbs_pkg::CFG_DATA_W-1:0] cfg_data,
	cbs_cell_if.sink                       cells,
	cbs_result_if.source                   result
);
	import cbs_pkg::*;

	localparam int unsigned IDX_W = idx_width(MAX_CELLS);
	localparam int unsigned CNT_W = cnt_width(MAX_CELLS);

	logic [VOLT_W-1:0]     threshold_q;
	logic [MAXB_W-1:0]     max_bal_q;
	logic [CNT_W-1:0]      cell_count_q;
	logic                  overflow_seen_q;
	logic [LIMIT_W-1:0]    limit_q;
	logic                  out_valid_q;
	logic [MASK_OUT_W-1:0] out_mask_q;
	logic [CNT_OUT_W-1:0]  out_count_q;
	logic                  out_overflow_q;

	sel_ctrl_t             ctrl;
	sel_stat_t             stat;
	logic                  accept, store_full, store_wr;
	logic [IDX_W-1:0]      rd_idx;
	logic [VOLT_W-1:0]     rd_data;
	logic [MASK_OUT_W-1:0] sel_mask;
	logic [CNT_OUT_W-1:0]  sel_count;

	// Input handshake and store write.
	assign cells.ready = !stat.busy;
	assign accept      = cells.valid && cells.ready;
	assign store_full  = (cell_count_q >= CNT_W'(MAX_CELLS));
	assign store_wr    = accept && !store_full;

	// Sequencer control.
	assign ctrl.start        = accept && cells.last_cell;
	assign ctrl.ack          = stat.done && (!out_valid_q || result.ready);
	assign ctrl.limit        = limit_q;
	assign ctrl.max_balanced = max_bal_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			max_bal_q   <= MAX_BAL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BALANCE_THRESHOLD: threshold_q <= cfg_data[VOLT_W-1:0];
				REG_MAX_BALANCED:      max_bal_q   <= cfg_data[MAXB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Frame tracking: fill count and dropped-cell flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_count_q    <= '0;
			overflow_seen_q <= 1'b0;
		end else if (ctrl.ack) begin
			cell_count_q    <= '0;
			overflow_seen_q <= 1'b0;
		end else if (accept) begin
			if (store_full) begin
				overflow_seen_q <= 1'b1;
			end else begin
				cell_count_q <= cell_count_q + CNT_W'(1);
			end
		end
	end

	// Threshold sum, formed without wrap on the last cell.
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			limit_q <= {1'b0, cells.pack_min_voltage} + {1'b0, threshold_q};
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.ack) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (ctrl.ack) begin
			out_mask_q     <= sel_mask;
			out_count_q    <= sel_count;
			out_overflow_q <= overflow_seen_q;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.discharge_mask = out_mask_q;
	assign result.balanced_count = out_count_q;
	assign result.overflow       = out_overflow_q;

	cbs_store #(
		.DEPTH (MAX_CELLS),
		.IDX_W (IDX_W)
	) u_store (
		.clk     (clk),
		.wr_en   (store_wr),
		.wr_idx  (cell_count_q[IDX_W-1:0]),
		.wr_data (cells.cell_voltage),
		.rd_idx  (rd_idx),
		.rd_data (rd_data)
	);

	cbs_select #(
		.DEPTH (MAX_CELLS),
		.IDX_W (IDX_W),
		.CNT_W (CNT_W)
	) u_select (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.cell_count (cell_count_q),
		.rd_idx     (rd_idx),
		.rd_data    (rd_data),
		.stat       (stat),
		.mask       (sel_mask),
		.count      (sel_count)
	);

endmodule
